// ----- rtl/sgi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_pkg: shared definitions for the segment intersection unit
// Coordinate widths, derived arithmetic widths and the structs that pass
// items between the pipeline sections.
// ----------------------------------------------------------------------------
package sgi_pkg;

    localparam int IN_W       = 16;
    localparam int OUT_W      = 24;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;

    // A coordinate difference needs one more bit; products of two of them
    // double that, and the difference of two products one more again.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = SUM_W;
    localparam int MUL_W  = MAG_W + DIFF_W;
    localparam int NUM_W  = MUL_W + FRAC_BITS;
    // The scaled quotient is at most |delta| * 2^FRAC_BITS.
    localparam int QUO_W  = COORD_BITS + FRAC_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic        [DIFF_W-1:0]     dmag_t;
    typedef logic        [MAG_W-1:0]      mag_t;
    typedef logic        [MUL_W-1:0]      mul_t;
    typedef logic        [NUM_W-1:0]      num_t;
    typedef logic        [QUO_W-1:0]      quo_t;
    typedef logic signed [OUT_W-1:0]      out_t;

    typedef struct packed {
        coord_t ax1;
        coord_t ay1;
        coord_t ax2;
        coord_t ay2;
        coord_t bx1;
        coord_t by1;
        coord_t bx2;
        coord_t by2;
    } seg_pair_t;

    typedef struct packed {
        sum_t   den;
        sum_t   tn;
        sum_t   un;
        coord_t base_x;
        coord_t base_y;
        diff_t  delta_x;
        diff_t  delta_y;
    } cross_t;

    typedef struct packed {
        logic   hit;
        coord_t base_x;
        coord_t base_y;
        logic   neg_x;
        logic   neg_y;
    } tag_t;

    typedef struct packed {
        tag_t tag;
        mag_t den;
        num_t num_x;
        num_t num_y;
    } div_in_t;

    typedef struct packed {
        tag_t tag;
        quo_t q_x;
        quo_t q_y;
    } div_out_t;

    function automatic diff_t coord_diff(coord_t a, coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

endpackage

// ----- rtl/sgi_cross.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_cross: cross-product section
// Three stages: coordinate differences, six products, then the
// denominator and the two parameter numerators.
// ----------------------------------------------------------------------------
module sgi_cross (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sgi_pkg::seg_pair_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sgi_pkg::cross_t    out_data
);

    logic s1_ready, s2_ready, s3_ready;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    sgi_pkg::diff_t  s1_dx12_reg, s1_dy12_reg, s1_dx34_reg, s1_dy34_reg;
    sgi_pkg::diff_t  s1_dx13_reg, s1_dy13_reg;
    sgi_pkg::coord_t s1_base_x_reg, s1_base_y_reg;

    sgi_pkg::prod_t  s2_pa_reg, s2_pb_reg, s2_pc_reg, s2_pd_reg, s2_pe_reg, s2_pf_reg;
    sgi_pkg::coord_t s2_base_x_reg, s2_base_y_reg;
    sgi_pkg::diff_t  s2_delta_x_reg, s2_delta_y_reg;

    sgi_pkg::cross_t s3_data_reg;
    sgi_pkg::cross_t s3_data_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_dx12_reg   <= sgi_pkg::coord_diff(in_data.ax1, in_data.ax2);
            s1_dy12_reg   <= sgi_pkg::coord_diff(in_data.ay1, in_data.ay2);
            s1_dx34_reg   <= sgi_pkg::coord_diff(in_data.bx1, in_data.bx2);
            s1_dy34_reg   <= sgi_pkg::coord_diff(in_data.by1, in_data.by2);
            s1_dx13_reg   <= sgi_pkg::coord_diff(in_data.ax1, in_data.bx1);
            s1_dy13_reg   <= sgi_pkg::coord_diff(in_data.ay1, in_data.by1);
            s1_base_x_reg <= in_data.ax1;
            s1_base_y_reg <= in_data.ay1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_pa_reg      <= sgi_pkg::prod_t'(s1_dx12_reg) * sgi_pkg::prod_t'(s1_dy34_reg);
            s2_pb_reg      <= sgi_pkg::prod_t'(s1_dy12_reg) * sgi_pkg::prod_t'(s1_dx34_reg);
            s2_pc_reg      <= sgi_pkg::prod_t'(s1_dx13_reg) * sgi_pkg::prod_t'(s1_dy34_reg);
            s2_pd_reg      <= sgi_pkg::prod_t'(s1_dy13_reg) * sgi_pkg::prod_t'(s1_dx34_reg);
            s2_pe_reg      <= sgi_pkg::prod_t'(s1_dx12_reg) * sgi_pkg::prod_t'(s1_dy13_reg);
            s2_pf_reg      <= sgi_pkg::prod_t'(s1_dy12_reg) * sgi_pkg::prod_t'(s1_dx13_reg);
            s2_base_x_reg  <= s1_base_x_reg;
            s2_base_y_reg  <= s1_base_y_reg;
            // The segment direction is end minus start, the negated difference.
            s2_delta_x_reg <= -s1_dx12_reg;
            s2_delta_y_reg <= -s1_dy12_reg;
        end
    end

    always_comb begin
        s3_data_next.den     = sgi_pkg::sum_t'(s2_pa_reg) - sgi_pkg::sum_t'(s2_pb_reg);
        s3_data_next.tn      = sgi_pkg::sum_t'(s2_pc_reg) - sgi_pkg::sum_t'(s2_pd_reg);
        s3_data_next.un      = sgi_pkg::sum_t'(s2_pf_reg) - sgi_pkg::sum_t'(s2_pe_reg);
        s3_data_next.base_x  = s2_base_x_reg;
        s3_data_next.base_y  = s2_base_y_reg;
        s3_data_next.delta_x = s2_delta_x_reg;
        s3_data_next.delta_y = s2_delta_y_reg;
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && s2_valid_reg) begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

// ----- rtl/sgi_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_classify: sign normalization, hit test and numerator scaling
// Two stages: make the denominator positive and take delta magnitudes,
// then test both parameters against [0,1] and form t * |delta| * 2^F.
// ----------------------------------------------------------------------------
module sgi_classify (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sgi_pkg::cross_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sgi_pkg::div_in_t  out_data
);

    logic s4_ready, s5_ready;
    logic s4_valid_reg, s5_valid_reg;

    logic            s4_zero_reg;
    sgi_pkg::sum_t   s4_den_reg, s4_tn_reg, s4_un_reg;
    sgi_pkg::coord_t s4_base_x_reg, s4_base_y_reg;
    sgi_pkg::dmag_t  s4_mag_x_reg, s4_mag_y_reg;
    logic            s4_neg_x_reg, s4_neg_y_reg;

    logic            flip;
    logic            hit_next;
    sgi_pkg::mul_t   prod_x, prod_y;

    sgi_pkg::div_in_t s5_data_reg;
    sgi_pkg::div_in_t s5_data_next;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    assign flip = in_data.den[sgi_pkg::SUM_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (s4_ready) begin
                s4_valid_reg <= in_valid;
            end
            if (s5_ready) begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_ready && in_valid) begin
            s4_zero_reg   <= (in_data.den == '0);
            s4_den_reg    <= flip ? -in_data.den : in_data.den;
            s4_tn_reg     <= flip ? -in_data.tn  : in_data.tn;
            s4_un_reg     <= flip ? -in_data.un  : in_data.un;
            s4_base_x_reg <= in_data.base_x;
            s4_base_y_reg <= in_data.base_y;
            s4_neg_x_reg  <= in_data.delta_x[sgi_pkg::DIFF_W-1];
            s4_neg_y_reg  <= in_data.delta_y[sgi_pkg::DIFF_W-1];
            s4_mag_x_reg  <= in_data.delta_x[sgi_pkg::DIFF_W-1]
                             ? sgi_pkg::dmag_t'(-in_data.delta_x)
                             : sgi_pkg::dmag_t'(in_data.delta_x);
            s4_mag_y_reg  <= in_data.delta_y[sgi_pkg::DIFF_W-1]
                             ? sgi_pkg::dmag_t'(-in_data.delta_y)
                             : sgi_pkg::dmag_t'(in_data.delta_y);
        end
    end

    always_comb begin
        // Both parameters lie in [0,1] exactly when 0 <= numerator <= den.
        hit_next = !s4_zero_reg
                   && !s4_tn_reg[sgi_pkg::SUM_W-1] && (s4_tn_reg <= s4_den_reg)
                   && !s4_un_reg[sgi_pkg::SUM_W-1] && (s4_un_reg <= s4_den_reg);
        prod_x = sgi_pkg::mul_t'(sgi_pkg::mag_t'(s4_tn_reg)) * sgi_pkg::mul_t'(s4_mag_x_reg);
        prod_y = sgi_pkg::mul_t'(sgi_pkg::mag_t'(s4_tn_reg)) * sgi_pkg::mul_t'(s4_mag_y_reg);

        s5_data_next.tag.hit    = hit_next;
        s5_data_next.tag.base_x = s4_base_x_reg;
        s5_data_next.tag.base_y = s4_base_y_reg;
        s5_data_next.tag.neg_x  = s4_neg_x_reg;
        s5_data_next.tag.neg_y  = s4_neg_y_reg;
        s5_data_next.den        = sgi_pkg::mag_t'(s4_den_reg);
        s5_data_next.num_x      = sgi_pkg::num_t'(prod_x) << sgi_pkg::FRAC_BITS;
        s5_data_next.num_y      = sgi_pkg::num_t'(prod_y) << sgi_pkg::FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (s5_ready && s4_valid_reg) begin
            s5_data_reg <= s5_data_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

endmodule

// ----- rtl/sgi_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_divider: pipelined restoring divider, two lanes
// One quotient bit per stage, most significant first, for the x and y
// numerators over the shared positive denominator.
// ----------------------------------------------------------------------------
module sgi_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sgi_pkg::div_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sgi_pkg::div_out_t  out_data
);

    localparam int STAGES = sgi_pkg::QUO_W;

    logic             valid_reg [STAGES];
    logic [STAGES:0]  ready_w;
    sgi_pkg::num_t    rem_x_reg [STAGES];
    sgi_pkg::num_t    rem_y_reg [STAGES];
    sgi_pkg::quo_t    quo_x_reg [STAGES];
    sgi_pkg::quo_t    quo_y_reg [STAGES];
    sgi_pkg::mag_t    den_reg   [STAGES];
    sgi_pkg::tag_t    tag_reg   [STAGES];

    assign ready_w[STAGES] = out_ready;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam int BIT = STAGES - 1 - i;

        logic          src_valid;
        sgi_pkg::num_t src_rx, src_ry;
        sgi_pkg::quo_t src_qx, src_qy;
        sgi_pkg::mag_t src_den;
        sgi_pkg::tag_t src_tag;
        sgi_pkg::num_t sub_w;
        sgi_pkg::num_t rem_x_next, rem_y_next;
        sgi_pkg::quo_t quo_x_next, quo_y_next;

        if (i == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_rx    = in_data.num_x;
            assign src_ry    = in_data.num_y;
            assign src_qx    = '0;
            assign src_qy    = '0;
            assign src_den   = in_data.den;
            assign src_tag   = in_data.tag;
        end else begin : g_chain
            assign src_valid = valid_reg[i-1];
            assign src_rx    = rem_x_reg[i-1];
            assign src_ry    = rem_y_reg[i-1];
            assign src_qx    = quo_x_reg[i-1];
            assign src_qy    = quo_y_reg[i-1];
            assign src_den   = den_reg[i-1];
            assign src_tag   = tag_reg[i-1];
        end

        assign ready_w[i] = !valid_reg[i] || ready_w[i+1];

        always_comb begin
            sub_w      = sgi_pkg::num_t'(src_den) << BIT;
            rem_x_next = src_rx;
            rem_y_next = src_ry;
            quo_x_next = src_qx;
            quo_y_next = src_qy;
            if (src_rx >= sub_w) begin
                rem_x_next      = src_rx - sub_w;
                quo_x_next[BIT] = 1'b1;
            end
            if (src_ry >= sub_w) begin
                rem_y_next      = src_ry - sub_w;
                quo_y_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (ready_w[i]) begin
                valid_reg[i] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (ready_w[i] && src_valid) begin
                rem_x_reg[i] <= rem_x_next;
                rem_y_reg[i] <= rem_y_next;
                quo_x_reg[i] <= quo_x_next;
                quo_y_reg[i] <= quo_y_next;
                den_reg[i]   <= src_den;
                tag_reg[i]   <= src_tag;
            end
        end
    end

    assign in_ready       = ready_w[0];
    assign out_valid      = valid_reg[STAGES-1];
    assign out_data.tag   = tag_reg[STAGES-1];
    assign out_data.q_x   = quo_x_reg[STAGES-1];
    assign out_data.q_y   = quo_y_reg[STAGES-1];

endmodule

// ----- rtl/segment_intersection_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_unit: exact intersection of two line segments
// Registers from input to result: 3 cross-product stages, 2 classify stages,
// 24 divider stages (one quotient bit each), 1 output. Throughput is one item
// per cycle when not stalled; each stage holds its item while the next one is
// full and not moving, so empty stages still fill during a stall. Synchronous
// active-low reset empties every stage; no result is pending.
// ----------------------------------------------------------------------------
module segment_intersection_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [sgi_pkg::IN_W-1:0]   s_a_start_x,
    input  logic signed [sgi_pkg::IN_W-1:0]   s_a_start_y,
    input  logic signed [sgi_pkg::IN_W-1:0]   s_a_end_x,
    input  logic signed [sgi_pkg::IN_W-1:0]   s_a_end_y,
    input  logic signed [sgi_pkg::IN_W-1:0]   s_b_start_x,
    input  logic signed [sgi_pkg::IN_W-1:0]   s_b_start_y,
    input  logic signed [sgi_pkg::IN_W-1:0]   s_b_end_x,
    input  logic signed [sgi_pkg::IN_W-1:0]   s_b_end_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [sgi_pkg::OUT_W-1:0]  m_cross_x_q8,
    output logic signed [sgi_pkg::OUT_W-1:0]  m_cross_y_q8
);

    sgi_pkg::seg_pair_t seg_in;
    sgi_pkg::cross_t    cross_data;
    sgi_pkg::div_in_t   cls_data;
    sgi_pkg::div_out_t  div_data;
    logic               cross_valid, cross_ready;
    logic               cls_valid, cls_ready;
    logic               div_valid, out_ready;

    logic               m_valid_reg;
    logic               m_hit_reg;
    sgi_pkg::out_t      m_x_reg, m_y_reg;
    sgi_pkg::out_t      base_x, base_y, q_x, q_y, x_next, y_next;

    // Only the low COORD_BITS of each input are used, taken as signed.
    assign seg_in.ax1 = sgi_pkg::coord_t'(s_a_start_x[sgi_pkg::COORD_BITS-1:0]);
    assign seg_in.ay1 = sgi_pkg::coord_t'(s_a_start_y[sgi_pkg::COORD_BITS-1:0]);
    assign seg_in.ax2 = sgi_pkg::coord_t'(s_a_end_x[sgi_pkg::COORD_BITS-1:0]);
    assign seg_in.ay2 = sgi_pkg::coord_t'(s_a_end_y[sgi_pkg::COORD_BITS-1:0]);
    assign seg_in.bx1 = sgi_pkg::coord_t'(s_b_start_x[sgi_pkg::COORD_BITS-1:0]);
    assign seg_in.by1 = sgi_pkg::coord_t'(s_b_start_y[sgi_pkg::COORD_BITS-1:0]);
    assign seg_in.bx2 = sgi_pkg::coord_t'(s_b_end_x[sgi_pkg::COORD_BITS-1:0]);
    assign seg_in.by2 = sgi_pkg::coord_t'(s_b_end_y[sgi_pkg::COORD_BITS-1:0]);

    sgi_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (seg_in),
        .out_valid (cross_valid),
        .out_ready (cross_ready),
        .out_data  (cross_data)
    );

    sgi_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cross_valid),
        .in_ready  (cross_ready),
        .in_data   (cross_data),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_data  (cls_data)
    );

    sgi_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_data   (cls_data),
        .out_valid (div_valid),
        .out_ready (out_ready),
        .out_data  (div_data)
    );

    assign out_ready = !m_valid_reg || m_ready;

    always_comb begin
        base_x = sgi_pkg::out_t'(div_data.tag.base_x) <<< sgi_pkg::FRAC_BITS;
        base_y = sgi_pkg::out_t'(div_data.tag.base_y) <<< sgi_pkg::FRAC_BITS;
        q_x    = sgi_pkg::out_t'(div_data.q_x);
        q_y    = sgi_pkg::out_t'(div_data.q_y);
        x_next = '0;
        y_next = '0;
        if (div_data.tag.hit) begin
            x_next = div_data.tag.neg_x ? (base_x - q_x) : (base_x + q_x);
            y_next = div_data.tag.neg_y ? (base_y - q_y) : (base_y + q_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && div_valid) begin
            m_hit_reg <= div_data.tag.hit;
            m_x_reg   <= x_next;
            m_y_reg   <= y_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_cross_x_q8 = m_x_reg;
    assign m_cross_y_q8 = m_y_reg;

endmodule
